>>> src/counting_semaphore_wait_queue_top_assert.svh
// Assertion macros for the semaphore block's checker.
// Needs nothing but a clock and reset expression at the point of use.
`ifndef COUNTING_SEMAPHORE_WAIT_QUEUE_TOP_ASSERT_SVH
`define COUNTING_SEMAPHORE_WAIT_QUEUE_TOP_ASSERT_SVH

// Same-cycle implication, off while reset is high
`define CSQ_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, off while reset is high
`define CSQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> src/csq_pkg.sv
// Shared types and constants for the counting semaphore with wait queue.
// No dependencies; the datapath, controller, top level, checkers and testbench import this package.
`default_nettype none

package csq_pkg;

   // Default sizes
   localparam int WAIT_DEPTH_DEF = 16;
   localparam int ID_BITS_DEF    = 8;
   localparam int COUNT_BITS_DEF = 16;

   // Fixed field widths
   localparam int CSR_W    = 16;
   localparam int STATUS_W = 3;

   // Operation codes
   localparam logic FUNC_DOWN = 1'b0;
   localparam logic FUNC_UP   = 1'b1;

   // Result codes
   typedef enum logic [STATUS_W-1:0] {
      STAT_ACQUIRED = 3'd0,
      STAT_QUEUED   = 3'd1,
      STAT_RAISED   = 3'd2,
      STAT_WOKEN    = 3'd3,
      STAT_FULL     = 3'd4,
      STAT_AT_MAX   = 3'd5
   } status_type;

   // Datapath flags seen by the controller
   typedef struct packed {
      logic count_zero;
      logic count_max;
      logic queue_empty;
      logic queue_full;
   } csq_dp_stat_type;

   // Controller commands to the datapath
   typedef struct packed {
      logic take;
      logic raise;
      logic push;
      logic pop;
      logic show_woken;
   } csq_cmd_type;

endpackage

`default_nettype wire

>>> src/csq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module csq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> src/csq_dpath.sv
// Datapath: unit count, wait queue pointers and occupancy, queue RAM.
// Depends on csq_pkg and csq_ram.
`default_nettype none

module csq_dpath
   import csq_pkg::*;
#(
   parameter int WAIT_DEPTH = WAIT_DEPTH_DEF,
   parameter int ID_BITS    = ID_BITS_DEF,
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_we,
   input  wire logic [CSR_W-1:0] csr_initial_count,
   input  wire logic [ID_BITS-1:0] req_thread_id,
   input  wire csq_cmd_type      cmd,
   output csq_dp_stat_type       stat,
   output logic [ID_BITS-1:0]    woken_thread
);

   localparam int PTR_W  = $clog2(WAIT_DEPTH);
   localparam int OCC_W  = $clog2(WAIT_DEPTH + 1);
   localparam int LOAD_W = (COUNT_BITS > CSR_W) ? COUNT_BITS : CSR_W;
   localparam logic [LOAD_W-1:0] COUNT_MAX_W = LOAD_W'({COUNT_BITS{1'b1}});
   localparam logic [PTR_W-1:0]  LAST_SLOT   = PTR_W'(WAIT_DEPTH - 1);
   localparam logic [OCC_W-1:0]  OCC_FULL    = OCC_W'(WAIT_DEPTH);

   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [PTR_W-1:0]      head_ff, head_in;
   logic [PTR_W-1:0]      tail_ff, tail_in;
   logic [OCC_W-1:0]      occ_ff, occ_in;
   logic [LOAD_W-1:0]     load_wide;
   logic [LOAD_W-1:0]     load_sat;
   logic [ID_BITS-1:0]    rd_data;

   // Wrap a queue pointer at the last slot
   function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      r = (p == LAST_SLOT) ? '0 : PTR_W'(p + 1'b1);
      return r;
   endfunction

   // Initial count saturates at the counter's range
   assign load_wide = LOAD_W'(csr_initial_count);
   assign load_sat  = (load_wide > COUNT_MAX_W) ? COUNT_MAX_W : load_wide;

   // Next-state logic; a register write overrides any command
   always_comb begin
      count_in = count_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      occ_in   = occ_ff;
      if (csr_we) begin
         count_in = load_sat[COUNT_BITS-1:0];
         head_in  = '0;
         tail_in  = '0;
         occ_in   = '0;
      end else begin
         if (cmd.take) begin
            count_in = count_ff - 1'b1;
         end
         if (cmd.raise) begin
            count_in = count_ff + 1'b1;
         end
         if (cmd.push) begin
            tail_in = next_slot(tail_ff);
            occ_in  = occ_ff + 1'b1;
         end
         if (cmd.pop) begin
            head_in = next_slot(head_ff);
            occ_in  = occ_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         head_ff  <= '0;
         tail_ff  <= '0;
         occ_ff   <= '0;
      end else begin
         count_ff <= count_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         occ_ff   <= occ_in;
      end
   end

   // Queue storage: write at tail, head read lands with the result beat
   csq_ram #(
      .WIDTH (ID_BITS),
      .DEPTH (WAIT_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (cmd.push && !csr_we),
      .wr_addr (tail_ff),
      .wr_data (req_thread_id),
      .rd_addr (head_ff),
      .rd_data (rd_data)
   );

   // Flags for the controller
   assign stat.count_zero  = (count_ff == '0);
   assign stat.count_max   = &count_ff;
   assign stat.queue_empty = (occ_ff == '0);
   assign stat.queue_full  = (occ_ff == OCC_FULL);

   assign woken_thread = cmd.show_woken ? rd_data : '0;

endmodule

`default_nettype wire

>>> src/csq_ctrl.sv
// Controller: accepts requests, decides the outcome, drives the datapath.
// Depends on csq_pkg.
`default_nettype none

module csq_ctrl
   import csq_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            start,
   input  wire logic            req_func,
   input  wire csq_dp_stat_type stat,
   output logic                 busy,
   output logic                 rsp_strobe,
   output logic [STATUS_W-1:0]  rsp_status,
   output logic                 rsp_woken_valid,
   output csq_cmd_type          cmd
);

   typedef enum logic [1:0] {
      ST_BOOT,
      ST_IDLE,
      ST_RESP
   } state_type;

   state_type  state_ff, state_in;
   logic       busy_ff, busy_in;
   logic       strobe_ff, strobe_in;
   status_type status_ff, status_in;
   logic       woken_ff, woken_in;
   logic       accept;
   status_type decide;
   logic       take, raise, push, pop;

   assign accept = start && !busy_ff;

   // Outcome of the request on the current count and queue
   always_comb begin
      take   = 1'b0;
      raise  = 1'b0;
      push   = 1'b0;
      pop    = 1'b0;
      decide = STAT_FULL;
      if (req_func == FUNC_DOWN) begin
         priority if (!stat.count_zero) begin
            take   = 1'b1;
            decide = STAT_ACQUIRED;
         end else if (!stat.queue_full) begin
            push   = 1'b1;
            decide = STAT_QUEUED;
         end else begin
            decide = STAT_FULL;
         end
      end else begin
         priority if (!stat.queue_empty) begin
            pop    = 1'b1;
            decide = STAT_WOKEN;
         end else if (!stat.count_max) begin
            raise  = 1'b1;
            decide = STAT_RAISED;
         end else begin
            decide = STAT_AT_MAX;
         end
      end
   end

   // Next state and registered outputs
   always_comb begin
      state_in  = state_ff;
      busy_in   = busy_ff;
      strobe_in = 1'b0;
      status_in = status_ff;
      woken_in  = 1'b0;
      unique case (state_ff)
         ST_BOOT: begin
            state_in = ST_IDLE;
            busy_in  = 1'b0;
         end
         ST_IDLE, ST_RESP: begin
            state_in  = accept ? ST_RESP : ST_IDLE;
            strobe_in = accept;
            woken_in  = accept && pop;
            if (accept) begin
               status_in = decide;
            end
         end
         default: begin
            state_in = ST_BOOT;
            busy_in  = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_BOOT;
         busy_ff   <= 1'b1;
         strobe_ff <= 1'b0;
         status_ff <= STAT_ACQUIRED;
         woken_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         busy_ff   <= busy_in;
         strobe_ff <= strobe_in;
         status_ff <= status_in;
         woken_ff  <= woken_in;
      end
   end

   // Commands act only on an accepted beat
   assign cmd.take       = accept && take;
   assign cmd.raise      = accept && raise;
   assign cmd.push       = accept && push;
   assign cmd.pop        = accept && pop;
   assign cmd.show_woken = woken_ff;

   assign busy            = busy_ff;
   assign rsp_strobe      = strobe_ff;
   assign rsp_status      = status_ff;
   assign rsp_woken_valid = woken_ff;

endmodule

`default_nettype wire

>>> src/counting_semaphore_wait_queue_top.sv
// Top level of the counting semaphore with FIFO wait queue.
// Depends on csq_pkg, csq_ctrl, csq_dpath (and csq_ram below it).
//
//   Channel   Ports                                   Handshake
//   request   req_func, req_thread_id                 start high, busy low
//   response  rsp_status, rsp_woken_valid/_thread     rsp_strobe, one cycle
//   config    csr_initial_count                       csr_we, one cycle
//
// A request's response beat comes in the cycle right after it is taken.
// A new request is taken every cycle while busy is low, also during a response
// beat; the response beat carries the controller's registered outcome and the
// queue RAM's registered head read.
// Reset is synchronous: busy is high while reset is held and in the boot state after it.
// The receiver cannot stall; a response beat is never held.
`default_nettype none

module counting_semaphore_wait_queue_top
   import csq_pkg::*;
#(
   parameter int WAIT_DEPTH = WAIT_DEPTH_DEF,
   parameter int ID_BITS    = ID_BITS_DEF,
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic               req_func,
   input  wire logic [ID_BITS-1:0] req_thread_id,
   output logic                    rsp_strobe,
   output logic [STATUS_W-1:0]     rsp_status,
   output logic                    rsp_woken_valid,
   output logic [ID_BITS-1:0]      rsp_woken_thread,
   input  wire logic               csr_we,
   input  wire logic [CSR_W-1:0]   csr_initial_count
);

   csq_cmd_type     cmd;
   csq_dp_stat_type stat;

   csq_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .req_func        (req_func),
      .stat            (stat),
      .busy            (busy),
      .rsp_strobe      (rsp_strobe),
      .rsp_status      (rsp_status),
      .rsp_woken_valid (rsp_woken_valid),
      .cmd             (cmd)
   );

   csq_dpath #(
      .WAIT_DEPTH (WAIT_DEPTH),
      .ID_BITS    (ID_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_initial_count (csr_initial_count),
      .req_thread_id     (req_thread_id),
      .cmd               (cmd),
      .stat              (stat),
      .woken_thread      (rsp_woken_thread)
   );

endmodule

`default_nettype wire

>>> src/csq_checker.sv
// Port-level checker for the semaphore top level, bound to it below.
// Depends on csq_pkg and the assertion macro header.
`default_nettype none

`include "counting_semaphore_wait_queue_top_assert.svh"

module csq_checker
   import csq_pkg::*;
#(
   parameter int ID_BITS = ID_BITS_DEF
) (
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                start,
   input wire logic                busy,
   input wire logic                rsp_strobe,
   input wire logic [STATUS_W-1:0] rsp_status,
   input wire logic                rsp_woken_valid,
   input wire logic [ID_BITS-1:0]  rsp_woken_thread
);

   // Every taken request gets its beat next cycle
   `CSQ_ASSERT_NEXT(a_beat_follows, clock, reset, start && !busy, rsp_strobe, "missing response beat")

   // No beat without a request the cycle before
   `CSQ_ASSERT_NEXT(a_no_extra_beat, clock, reset, !(start && !busy), !rsp_strobe, "response beat without request")

   // Woken flag goes with the woken code
   `CSQ_ASSERT_NOW(a_woken_code, clock, reset, rsp_strobe, rsp_woken_valid == (rsp_status == STAT_WOKEN), "woken flag and status disagree")

   // Thread id is zero unless a waiter was released
   `CSQ_ASSERT_NOW(a_woken_zero, clock, reset, rsp_strobe && !rsp_woken_valid, rsp_woken_thread == '0, "woken id not zero")

endmodule

bind counting_semaphore_wait_queue_top csq_checker #(
   .ID_BITS (ID_BITS)
) u_csq_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .rsp_strobe       (rsp_strobe),
   .rsp_status       (rsp_status),
   .rsp_woken_valid  (rsp_woken_valid),
   .rsp_woken_thread (rsp_woken_thread)
);

`default_nettype wire

>>> tb/semaphore_checker.sv
// Watcher, predictor and comparator for the counting semaphore with wait queue.
// Depends on csq_pkg; instantiated next to the block by tb/testbench.sv.
module semaphore_checker
   import csq_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic                      busy,
   input  logic                      req_func,
   input  logic [ID_BITS_DEF-1:0]    req_thread_id,
   input  logic                      rsp_strobe,
   input  logic [STATUS_W-1:0]       rsp_status,
   input  logic                      rsp_woken_valid,
   input  logic [ID_BITS_DEF-1:0]    rsp_woken_thread,
   input  logic                      csr_we,
   input  logic [CSR_W-1:0]          csr_initial_count,
   output int                        mismatches,
   output int                        replies_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint unsigned COUNT_CEILING = (64'd1 << COUNT_BITS_DEF) - 64'd1;

   typedef struct {
      status_type               status;
      logic                     woken_valid;
      logic [ID_BITS_DEF-1:0]   woken_thread;
   } semaphore_reply_type;

   // Shadow semaphore state
   longint unsigned            free_units;
   logic [ID_BITS_DEF-1:0]     waiter_ids [WAIT_DEPTH_DEF];
   int unsigned                wait_head;
   int unsigned                wait_tail;
   int unsigned                waiter_total;

   semaphore_reply_type        replies_due [$];
   int                         fail_total = 0;

   function automatic void flag_mismatch(input string detail);
      fail_total++;
      if (fail_total <= 10)
         $display("mismatch @%0t: %s", $time, detail);
   endfunction

   // Register write: load the count (saturating) and drop every waiter
   function automatic void load_units(input logic [CSR_W-1:0] value);
      free_units   = (longint'(value) > COUNT_CEILING) ? COUNT_CEILING : longint'(value);
      wait_head    = 0;
      wait_tail    = 0;
      waiter_total = 0;
   endfunction

   // One down or up; updates the shadow state and returns the reply it causes
   function automatic semaphore_reply_type predict_semaphore_op(input logic func,
                                                                input logic [ID_BITS_DEF-1:0] tid);
      semaphore_reply_type r;
      r.woken_valid  = 1'b0;
      r.woken_thread = '0;
      if (func == FUNC_DOWN) begin
         if (free_units > 0) begin
            free_units--;
            r.status = STAT_ACQUIRED;
         end else if (waiter_total < WAIT_DEPTH_DEF) begin
            waiter_ids[wait_tail] = tid;
            wait_tail = (wait_tail == WAIT_DEPTH_DEF - 1) ? 0 : wait_tail + 1;
            waiter_total++;
            r.status = STAT_QUEUED;
         end else begin
            r.status = STAT_FULL;
         end
      end else begin
         if (waiter_total > 0) begin
            r.woken_valid  = 1'b1;
            r.woken_thread = waiter_ids[wait_head];
            wait_head = (wait_head == WAIT_DEPTH_DEF - 1) ? 0 : wait_head + 1;
            waiter_total--;
            r.status = STAT_WOKEN;
         end else if (free_units < COUNT_CEILING) begin
            free_units++;
            r.status = STAT_RAISED;
         end else begin
            r.status = STAT_AT_MAX;
         end
      end
      return r;
   endfunction

   // Response beat first (belongs to an older request), then writes, then new requests
   always @(posedge clock) begin
      semaphore_reply_type want;
      if (reset) begin
         free_units   = 0;
         wait_head    = 0;
         wait_tail    = 0;
         waiter_total = 0;
         replies_due.delete();
      end else begin
         if (rsp_strobe) begin
            if (replies_due.size() == 0) begin
               flag_mismatch($sformatf("response beat with none due: status=%0d valid=%0b id=%0h",
                                       rsp_status, rsp_woken_valid, rsp_woken_thread));
            end else begin
               want = replies_due.pop_front();
               if (rsp_status !== want.status || rsp_woken_valid !== want.woken_valid ||
                   rsp_woken_thread !== want.woken_thread)
                  flag_mismatch($sformatf(
                     "expected status=%0d valid=%0b id=%0h, got status=%0d valid=%0b id=%0h",
                     want.status, want.woken_valid, want.woken_thread,
                     rsp_status, rsp_woken_valid, rsp_woken_thread));
            end
         end
         if (csr_we)
            load_units(csr_initial_count);
         if (start && !busy)
            replies_due.push_back(predict_semaphore_op(req_func, req_thread_id));
      end
      replies_pending <= replies_due.size();
      mismatches      <= fail_total;
   end

endmodule

>>> tb/testbench.sv
// Stimulus and verdict for counting_semaphore_wait_queue_top.
// Depends on csq_pkg, the block's RTL and tb/semaphore_checker.sv.
module testbench;
   import csq_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic                     req_func = FUNC_DOWN;
   logic [ID_BITS_DEF-1:0]   req_thread_id = '0;
   logic                     csr_we = 1'b0;
   logic [CSR_W-1:0]         csr_initial_count = '0;

   logic                     busy;
   logic                     rsp_strobe;
   logic [STATUS_W-1:0]      rsp_status;
   logic                     rsp_woken_valid;
   logic [ID_BITS_DEF-1:0]   rsp_woken_thread;

   int                       mismatches;
   int                       replies_pending;

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   counting_semaphore_wait_queue_top u_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_func          (req_func),
      .req_thread_id     (req_thread_id),
      .rsp_strobe        (rsp_strobe),
      .rsp_status        (rsp_status),
      .rsp_woken_valid   (rsp_woken_valid),
      .rsp_woken_thread  (rsp_woken_thread),
      .csr_we            (csr_we),
      .csr_initial_count (csr_initial_count)
   );

   semaphore_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_func          (req_func),
      .req_thread_id     (req_thread_id),
      .rsp_strobe        (rsp_strobe),
      .rsp_status        (rsp_status),
      .rsp_woken_valid   (rsp_woken_valid),
      .rsp_woken_thread  (rsp_woken_thread),
      .csr_we            (csr_we),
      .csr_initial_count (csr_initial_count),
      .mismatches        (mismatches),
      .replies_pending   (replies_pending)
   );

   // Present one request beat and hold it until taken
   task automatic issue_op(input logic func, input logic [ID_BITS_DEF-1:0] tid);
      start         <= 1'b1;
      req_func      <= func;
      req_thread_id <= tid;
      do @(posedge clock); while (busy !== 1'b0);
   endtask

   task automatic hold_off(input int cycles);
      if (cycles > 0) begin
         start <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   // Stop requests and wait for every reply beat to come back
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (replies_pending != 0) @(posedge clock);
   endtask

   task automatic load_initial_count(input logic [CSR_W-1:0] value);
      drain();
      csr_we            <= 1'b1;
      csr_initial_count <= value;
      @(posedge clock);
      csr_we            <= 1'b0;
   endtask

   // Mostly none, often short, now and then long
   function automatic int draw_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      else if (r < 95)
         return $urandom_range(1, 3);
      else
         return $urandom_range(8, 40);
   endfunction

   initial begin
      logic [CSR_W-1:0] phase_counts [8];
      int               up_pct;
      bit               gapless;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      do @(posedge clock); while (busy !== 1'b0);

      // Count at the top: refused up, then take one and give it back
      load_initial_count(16'hFFFF);
      issue_op(FUNC_UP,   8'h01);
      issue_op(FUNC_DOWN, 8'h02);
      issue_op(FUNC_UP,   8'h03);

      // Empty count: raise and take, fill the queue, overflow it, wake in order
      load_initial_count(16'h0000);
      issue_op(FUNC_UP,   8'h10);
      issue_op(FUNC_DOWN, 8'h11);
      for (int n = 0; n < WAIT_DEPTH_DEF; n++)
         issue_op(FUNC_DOWN, (n == 0) ? 8'h00 : (n == 1) ? 8'hFF :
                             (n < 4) ? 8'hA5 : 8'(n * 8'h13));
      issue_op(FUNC_DOWN, 8'h5A);
      issue_op(FUNC_UP,   8'h00);
      issue_op(FUNC_UP,   8'h00);

      // Random phases over a spread of starting counts
      phase_counts = '{16'd0, 16'hFFFF, 16'd1, 16'hFFFE, 16'd0, 16'd0, 16'd2, 16'd0};
      phase_counts[4] = CSR_W'($urandom_range(3, 20));
      phase_counts[5] = CSR_W'($urandom_range(0, 65535));
      for (int phase = 0; phase < 8; phase++) begin
         load_initial_count(phase_counts[phase]);
         up_pct  = (phase == 1) ? 75 : $urandom_range(20, 80);
         gapless = ($urandom_range(0, 2) == 0);
         for (int n = 0; n < 125; n++) begin
            issue_op(($urandom_range(0, 99) < up_pct) ? FUNC_UP : FUNC_DOWN,
                     ID_BITS_DEF'($urandom_range(0, 255)));
            if (!gapless)
               hold_off(draw_gap());
         end
      end

      drain();
      repeat (5) @(posedge clock);
      if (mismatches == 0)
         $display("counting_semaphore_wait_queue_top verification clean");
      else
         $display("counting_semaphore_wait_queue_top verification failed");
      $finish;
   end

   // Run limit
   initial begin
      #2_000_000;
      $display("counting_semaphore_wait_queue_top verification failed");
      $finish;
   end

endmodule
